/* hdl/pfc_pkg.sv */
// Shared types, constants and helpers for the Playfair digraph cipher.
`timescale 1ns / 1ps

package pfc_pkg;

    localparam int SIDE      = 5;
    localparam int CODE_W    = 5;
    localparam int POS_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 50;
    localparam int ROW_PAIR_W = 2 * SIDE * CODE_W;
    localparam int ROW_W      = SIDE * CODE_W;

    localparam logic [CODE_W-1:0] LETTER_I = 5'd8;
    localparam logic [CODE_W-1:0] LETTER_J = 5'd9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENCRYPT_MODE = 2'd0,
        REG_ROWS_0_1     = 2'd1,
        REG_ROWS_2_3     = 2'd2,
        REG_ROW_4        = 2'd3
    } t_reg_idx;

    // Key square as [row][column][code bits], row 0 and column 0 lowest.
    typedef logic [SIDE-1:0][SIDE-1:0][CODE_W-1:0] t_square;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_pos;

    typedef struct packed {
        t_pos pos1;
        t_pos pos2;
        logic found;
    } t_loc;

    typedef struct packed {
        t_pos pos1;
        t_pos pos2;
        logic miss;
    } t_sel;

    // Step one place round the square, forwards or backwards.
    function automatic logic [POS_W-1:0] shift5(input logic [POS_W-1:0] v,
                                                input logic enc);
        logic [POS_W-1:0] res;
        res = '0;
        case (v)
            3'd0:    res = enc ? 3'd1 : 3'd4;
            3'd1:    res = enc ? 3'd2 : 3'd0;
            3'd2:    res = enc ? 3'd3 : 3'd1;
            3'd3:    res = enc ? 3'd4 : 3'd2;
            3'd4:    res = enc ? 3'd0 : 3'd3;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

/* hdl/pfc_locate.sv */
// First pipeline stage: finds both letters in the key square.
`timescale 1ns / 1ps

module pfc_locate (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [pfc_pkg::CODE_W-1:0]   i_first,
    input  logic [pfc_pkg::CODE_W-1:0]   i_second,
    input  pfc_pkg::t_square             i_square,
    output logic                         o_valid,
    output pfc_pkg::t_loc                o_loc
);
    import pfc_pkg::*;

    logic        r_valid;
    t_loc        r_loc;
    t_loc        n_loc;
    logic [CODE_W-1:0] w_key1;
    logic [CODE_W-1:0] w_key2;
    logic        w_f1;
    logic        w_f2;
    t_pos        w_p1;
    t_pos        w_p2;

    // The letter j shares the cell of i.
    assign w_key1 = (i_first  == LETTER_J) ? LETTER_I : i_first;
    assign w_key2 = (i_second == LETTER_J) ? LETTER_I : i_second;

    // Scanned from the last cell back so that the first match in row-major order wins.
    always_comb begin
        w_f1 = 1'b0;
        w_f2 = 1'b0;
        w_p1 = '0;
        w_p2 = '0;
        for (int k = SIDE * SIDE - 1; k >= 0; k--) begin
            if (i_square[k / SIDE][k % SIDE] == w_key1) begin
                w_f1     = 1'b1;
                w_p1.row = POS_W'(k / SIDE);
                w_p1.col = POS_W'(k % SIDE);
            end
            if (i_square[k / SIDE][k % SIDE] == w_key2) begin
                w_f2     = 1'b1;
                w_p2.row = POS_W'(k / SIDE);
                w_p2.col = POS_W'(k % SIDE);
            end
        end
        n_loc.pos1  = w_p1;
        n_loc.pos2  = w_p2;
        n_loc.found = w_f1 & w_f2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_loc <= n_loc;
        end
    end

    assign o_valid = r_valid;
    assign o_loc   = r_loc;

endmodule

/* hdl/pfc_rule.sv */
// Second pipeline stage: applies the Playfair rules to the two positions.
`timescale 1ns / 1ps

module pfc_rule (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  pfc_pkg::t_loc i_loc,
    input  logic          i_encrypt,
    output logic          o_valid,
    output pfc_pkg::t_sel o_sel
);
    import pfc_pkg::*;

    logic r_valid;
    t_sel r_sel;
    t_sel n_sel;
    logic w_same_row;
    logic w_same_col;

    assign w_same_row = (i_loc.pos1.row == i_loc.pos2.row);
    assign w_same_col = (i_loc.pos1.col == i_loc.pos2.col);

    always_comb begin
        n_sel.miss = ~i_loc.found;
        if (w_same_row && w_same_col) begin
            n_sel.pos1.row = shift5(i_loc.pos1.row, i_encrypt);
            n_sel.pos1.col = shift5(i_loc.pos1.col, i_encrypt);
            n_sel.pos2     = n_sel.pos1;
        end else if (w_same_row) begin
            n_sel.pos1.row = i_loc.pos1.row;
            n_sel.pos1.col = shift5(i_loc.pos1.col, i_encrypt);
            n_sel.pos2.row = i_loc.pos2.row;
            n_sel.pos2.col = shift5(i_loc.pos2.col, i_encrypt);
        end else if (w_same_col) begin
            n_sel.pos1.row = shift5(i_loc.pos1.row, i_encrypt);
            n_sel.pos1.col = i_loc.pos1.col;
            n_sel.pos2.row = shift5(i_loc.pos2.row, i_encrypt);
            n_sel.pos2.col = i_loc.pos2.col;
        end else begin
            n_sel.pos1.row = i_loc.pos1.row;
            n_sel.pos1.col = i_loc.pos2.col;
            n_sel.pos2.row = i_loc.pos2.row;
            n_sel.pos2.col = i_loc.pos1.col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel <= n_sel;
        end
    end

    assign o_valid = r_valid;
    assign o_sel   = r_sel;

endmodule

/* hdl/pfc_lookup.sv */
// Third pipeline stage: reads the result letters back out of the key square.
`timescale 1ns / 1ps

module pfc_lookup (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  pfc_pkg::t_sel               i_sel,
    input  pfc_pkg::t_square            i_square,
    output logic                        o_valid,
    output logic [pfc_pkg::CODE_W-1:0]  o_first,
    output logic [pfc_pkg::CODE_W-1:0]  o_second,
    output logic                        o_miss
);
    import pfc_pkg::*;

    logic              r_valid;
    logic [CODE_W-1:0] r_first;
    logic [CODE_W-1:0] r_second;
    logic              r_miss;
    logic [CODE_W-1:0] n_first;
    logic [CODE_W-1:0] n_second;

    // A missing letter forces both result letters to zero.
    always_comb begin
        n_first  = '0;
        n_second = '0;
        if (!i_sel.miss) begin
            n_first  = i_square[i_sel.pos1.row][i_sel.pos1.col];
            n_second = i_square[i_sel.pos2.row][i_sel.pos2.col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_miss   <= i_sel.miss;
        end
    end

    assign o_valid  = r_valid;
    assign o_first  = r_first;
    assign o_second = r_second;
    assign o_miss   = r_miss;

endmodule

/* hdl/playfair_digraph_cipher.sv */
// Top level of the Playfair digraph cipher: configuration registers and the three-stage pipeline.
//
//  channel   direction  contents
//  s_axis    in         tdata: first_letter[4:0], second_letter[9:5], zero fill
//  m_axis    out        tdata: out_first[4:0], out_second[9:5]; tuser: not_in_square
//  cfg       in         i_cfg_we, i_cfg_idx, i_cfg_data (mode, two row pairs, row 4)
//
// One word is taken per cycle unless a stall at the output backs up to the first stage; each word
// passes through locate, apply the rule and read back the square, each ending in a register.
// Synchronous active-low reset empties the pipeline and restores encrypt mode and
// an all-zero square. A stall at the output holds each full stage with no empty stage
// after it; empty stages keep filling, so no word is lost or repeated.
`timescale 1ns / 1ps

module playfair_digraph_cipher (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pfc_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,  // first_letter, second_letter
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // out_first, out_second
    output logic                               m_axis_tuser   // not_in_square
);
    import pfc_pkg::*;

    logic                  r_encrypt;
    logic [ROW_PAIR_W-1:0] r_rows_0_1;
    logic [ROW_PAIR_W-1:0] r_rows_2_3;
    logic [ROW_W-1:0]      r_row_4;
    t_square               w_square;

    logic        w_en1, w_en2, w_en3;
    logic        w_v1, w_v2, w_v3;
    t_loc        w_loc;
    t_sel        w_sel;
    logic [CODE_W-1:0] w_first;
    logic [CODE_W-1:0] w_second;
    logic        w_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encrypt  <= 1'b1;
            r_rows_0_1 <= '0;
            r_rows_2_3 <= '0;
            r_row_4    <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ENCRYPT_MODE: r_encrypt  <= i_cfg_data[0];
                REG_ROWS_0_1:     r_rows_0_1 <= i_cfg_data[ROW_PAIR_W-1:0];
                REG_ROWS_2_3:     r_rows_2_3 <= i_cfg_data[ROW_PAIR_W-1:0];
                REG_ROW_4:        r_row_4    <= i_cfg_data[ROW_W-1:0];
                default:          r_encrypt  <= r_encrypt;
            endcase
        end
    end

    assign w_square = {r_row_4, r_rows_2_3, r_rows_0_1};

    // A stage moves on when it is empty or the stage after it moves on.
    assign w_en3 = ~w_v3 | m_axis_tready;
    assign w_en2 = ~w_v2 | w_en3;
    assign w_en1 = ~w_v1 | w_en2;
    assign s_axis_tready = w_en1;

    pfc_locate u_locate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en1),
        .i_valid  (s_axis_tvalid),
        .i_first  (s_axis_tdata[CODE_W-1:0]),
        .i_second (s_axis_tdata[2*CODE_W-1:CODE_W]),
        .i_square (w_square),
        .o_valid  (w_v1),
        .o_loc    (w_loc)
    );

    pfc_rule u_rule (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en2),
        .i_valid   (w_v1),
        .i_loc     (w_loc),
        .i_encrypt (r_encrypt),
        .o_valid   (w_v2),
        .o_sel     (w_sel)
    );

    pfc_lookup u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en3),
        .i_valid  (w_v2),
        .i_sel    (w_sel),
        .i_square (w_square),
        .o_valid  (w_v3),
        .o_first  (w_first),
        .o_second (w_second),
        .o_miss   (w_miss)
    );

    assign m_axis_tvalid = w_v3;
    assign m_axis_tdata  = {6'd0, w_second, w_first};
    assign m_axis_tuser  = w_miss;

endmodule

/* tb/tb_playfair_digraph_cipher.sv */
// Self-checking testbench for the Playfair digraph cipher stream block.
`timescale 1ns / 1ps

module tb_playfair_digraph_cipher;

    import pfc_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] first;
        logic [CODE_W-1:0] second;
        logic              miss;
    } t_digraph_out;

    typedef struct packed {
        logic [CODE_W-1:0] first;
        logic [CODE_W-1:0] second;
        logic              known;
        t_digraph_out      res;
    } t_dir_row;

    localparam int SETS_PER_PHASE = 4;
    localparam int WORDS_PER_SET  = 82;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]  i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;
    logic              m_axis_tuser;

    // Shadow copies of the configuration registers, as last written.
    bit                sh_enc    = 1'b1;
    logic [49:0]       sh_rows01 = '0;
    logic [49:0]       sh_rows23 = '0;
    logic [24:0]       sh_row4   = '0;

    t_digraph_out      cipher_q[$];
    logic [CODE_W-1:0] next_cells [25];
    int                send_idle_pct = 0;
    int                stall_pct     = 0;
    int                errors        = 0;
    int                words_sent    = 0;
    int                words_checked = 0;
    int                squares_loaded = 0;
    int                SEND_IDLE [4] = '{0, 73, 0, 15};
    int                STALL [4]     = '{0, 0, 73, 15};

    // The first four rows hold after reset (encrypt mode, all-zero square); the rest
    // are run against the textbook square in both modes.
    t_dir_row dir_tab [14] = '{
        '{5'd0,  5'd0,  1'b1, '{5'd0, 5'd0, 1'b0}},
        '{5'd0,  5'd1,  1'b1, '{5'd0, 5'd0, 1'b1}},
        '{5'd31, 5'd31, 1'b1, '{5'd0, 5'd0, 1'b1}},
        '{5'd9,  5'd0,  1'b1, '{5'd0, 5'd0, 1'b1}},
        '{5'd15, 5'd5,  1'b0, '0},
        '{5'd0,  5'd21, 1'b0, '0},
        '{5'd7,  5'd8,  1'b0, '0},
        '{5'd4,  5'd4,  1'b0, '0},
        '{5'd9,  5'd2,  1'b0, '0},
        '{5'd25, 5'd19, 1'b0, '0},
        '{5'd24, 5'd22, 1'b0, '0},
        '{5'd26, 5'd0,  1'b0, '0},
        '{5'd0,  5'd25, 1'b0, '0},
        '{5'd12, 5'd1,  1'b0, '0}
    };

    playfair_digraph_cipher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // first_letter, second_letter
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_first, out_second
        .m_axis_tuser  (m_axis_tuser)    // not_in_square
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [CODE_W-1:0] cell_at(input int row, input int col);
        if (row < 2)
            return sh_rows01[(row * SIDE + col) * CODE_W +: CODE_W];
        else if (row < 4)
            return sh_rows23[((row - 2) * SIDE + col) * CODE_W +: CODE_W];
        return sh_row4[col * CODE_W +: CODE_W];
    endfunction

    // Row-major search, so a duplicated letter is found at its first cell.
    function automatic bit find_cell(input logic [CODE_W-1:0] code,
                                     output int row, output int col);
        logic [CODE_W-1:0] key;
        key = (code == LETTER_J) ? LETTER_I : code;
        row = 0;
        col = 0;
        for (int r = 0; r < SIDE; r++)
            for (int c = 0; c < SIDE; c++)
                if (cell_at(r, c) == key) begin
                    row = r;
                    col = c;
                    return 1'b1;
                end
        return 1'b0;
    endfunction

    function automatic int step5(input int v);
        return sh_enc ? (v + 1) % SIDE : (v + SIDE - 1) % SIDE;
    endfunction

    function automatic t_digraph_out playfair_expect(input logic [CODE_W-1:0] a,
                                                    input logic [CODE_W-1:0] b);
        int r1, c1, r2, c2, nr1, nc1, nr2, nc2;
        bit f1, f2;
        t_digraph_out res;
        f1 = find_cell(a, r1, c1);
        f2 = find_cell(b, r2, c2);
        if (!f1 || !f2) begin
            res = '{first: '0, second: '0, miss: 1'b1};
            return res;
        end
        if (r1 == r2 && c1 == c2) begin
            nr1 = step5(r1); nc1 = step5(c1);
            nr2 = nr1;       nc2 = nc1;
        end else if (r1 == r2) begin
            nr1 = r1; nc1 = step5(c1);
            nr2 = r2; nc2 = step5(c2);
        end else if (c1 == c2) begin
            nr1 = step5(r1); nc1 = c1;
            nr2 = step5(r2); nc2 = c2;
        end else begin
            nr1 = r1; nc1 = c2;
            nr2 = r2; nc2 = c1;
        end
        res = '{first: cell_at(nr1, nc1), second: cell_at(nr2, nc2), miss: 1'b0};
        return res;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_ENCRYPT_MODE: sh_enc    = data[0];
            REG_ROWS_0_1:     sh_rows01 = data;
            REG_ROWS_2_3:     sh_rows23 = data;
            REG_ROW_4:        sh_row4   = data[ROW_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Loads next_cells and the mode; junk above the mode bit and the row 4 field checks the masking.
    task automatic load_square(input bit enc);
        logic [CFG_W-1:0] pair01, pair23, row4, mode;
        pair01 = '0;
        pair23 = '0;
        row4   = CFG_W'({$urandom, $urandom});
        mode   = CFG_W'({$urandom, $urandom});
        mode[0] = enc;
        for (int k = 0; k < 2 * SIDE; k++) begin
            pair01[k * CODE_W +: CODE_W] = next_cells[k];
            pair23[k * CODE_W +: CODE_W] = next_cells[2 * SIDE + k];
        end
        for (int k = 0; k < SIDE; k++)
            row4[k * CODE_W +: CODE_W] = next_cells[4 * SIDE + k];
        write_reg(REG_ENCRYPT_MODE, mode);
        write_reg(REG_ROWS_0_1, pair01);
        write_reg(REG_ROWS_2_3, pair23);
        write_reg(REG_ROW_4, row4);
        i_cfg_we <= 1'b0;
        squares_loaded++;
    endtask

    // Mostly a proper square of 25 distinct letters without j; the rest carry
    // duplicates, gaps, j cells and codes above z.
    task automatic make_square();
        int pool [25];
        int n, k, tmp, pick;
        n = 0;
        for (int l = 0; l < 26; l++)
            if (l != LETTER_J) begin
                pool[n] = l;
                n++;
            end
        for (int i = 24; i > 0; i--) begin
            k = $urandom_range(i);
            tmp = pool[i];
            pool[i] = pool[k];
            pool[k] = tmp;
        end
        pick = $urandom_range(99);
        for (int i = 0; i < 25; i++) begin
            next_cells[i] = CODE_W'(pool[i]);
            if (pick >= 85 || (pick >= 70 && $urandom_range(7) == 0))
                next_cells[i] = CODE_W'($urandom_range(31));
        end
    endtask

    // Most letters are drawn from the loaded square so that the row, column and
    // identical-cell rules come up often.
    task automatic pick_digraph(output logic [CODE_W-1:0] a, output logic [CODE_W-1:0] b);
        int r1, c1, r2, c2;
        if ($urandom_range(99) < 10) begin
            a = CODE_W'($urandom_range(31));
            b = CODE_W'($urandom_range(31));
            return;
        end
        r1 = $urandom_range(4);
        c1 = $urandom_range(4);
        r2 = $urandom_range(4);
        c2 = $urandom_range(4);
        case ($urandom_range(3))
            0: begin r2 = r1; c2 = c1; end
            1: begin r2 = r1; c2 = (c1 + 1 + $urandom_range(3)) % SIDE; end
            2: begin c2 = c1; r2 = (r1 + 1 + $urandom_range(3)) % SIDE; end
            default: ;
        endcase
        a = cell_at(r1, c1);
        b = cell_at(r2, c2);
        if (a == LETTER_I && $urandom_range(1) == 1)
            a = LETTER_J;
        if (b == LETTER_I && $urandom_range(1) == 1)
            b = LETTER_J;
    endtask

    task automatic send_digraph(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b,
                                input bit known, input t_digraph_out typed);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        cipher_q.push_back(known ? typed : playfair_expect(a, b));
        words_sent++;
    endtask

    // The pipeline gives a word for every word taken, so an empty queue means idle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_directed(input int lo, input int hi);
        for (int i = lo; i <= hi; i++)
            send_digraph(dir_tab[i].first, dir_tab[i].second, dir_tab[i].known, dir_tab[i].res);
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        t_digraph_out want;
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cipher_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, got tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = cipher_q.pop_front();
                words_checked++;
                if (m_axis_tdata[4:0] !== want.first) begin
                    errors++;
                    $display("%0t: out_first expected %0d, got %0d",
                             $time, want.first, m_axis_tdata[4:0]);
                end
                if (m_axis_tdata[9:5] !== want.second) begin
                    errors++;
                    $display("%0t: out_second expected %0d, got %0d",
                             $time, want.second, m_axis_tdata[9:5]);
                end
                if (m_axis_tuser !== want.miss) begin
                    errors++;
                    $display("%0t: not_in_square expected %0d, got %0d",
                             $time, want.miss, m_axis_tuser);
                end
            end
        end
    end

    initial begin
        logic [CODE_W-1:0] a, b;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed(0, 3);
        next_cells = '{5'd15, 5'd11, 5'd0,  5'd24, 5'd5,  5'd8,  5'd17, 5'd4,  5'd23,
                       5'd12, 5'd1,  5'd2,  5'd3,  5'd6,  5'd7,  5'd10, 5'd13, 5'd14,
                       5'd16, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd25};
        load_square(1'b1);
        run_directed(4, 13);
        write_reg(REG_ENCRYPT_MODE, '0);
        i_cfg_we <= 1'b0;
        run_directed(4, 13);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = SEND_IDLE[ph];
            stall_pct     = STALL[ph];
            for (int s = 0; s < SETS_PER_PHASE; s++) begin
                wait_idle();
                if (s == 0 && ph < 2) begin
                    // Extremes: every cell all ones, then every cell zero.
                    for (int i = 0; i < 25; i++)
                        next_cells[i] = (ph == 0) ? 5'd31 : 5'd0;
                    load_square(ph == 1);
                end else begin
                    make_square();
                    load_square($urandom_range(1));
                end
                repeat (WORDS_PER_SET) begin
                    pick_digraph(a, b);
                    send_digraph(a, b, 1'b0, '0);
                end
            end
        end
        wait_idle();

        $display("Sent %0d digraphs and checked %0d results over %0d key square loads,",
                 words_sent, words_checked, squares_loaded);
        $display("in both modes, with sender gaps and receiver stalls.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #400000;
        $display("Timed out with %0d words still outstanding.", cipher_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
